/* src/etcas_pkg.sv */
package etcas_pkg;

    // Arm storage size
    localparam int NUM_ARMS = 8;
    localparam int ARM_W    = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
    localparam int ARMCNT_W = $clog2(NUM_ARMS + 1);

    // Field widths
    localparam int IDX_W    = 3;
    localparam int DATA_W   = 32;
    localparam int NARMS_W  = 4;
    localparam int DIVCNT_W = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] CNT_MAX = '1;

    // Request commands
    localparam logic CMD_CHOOSE = 1'b0;
    localparam logic CMD_RECORD = 1'b1;

    // Configuration register indexes
    localparam logic CFG_EXPLORE_LIMIT = 1'b0;
    localparam logic CFG_NUM_ARMS      = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_BUMP,
        ST_INC,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_WRITE,
        ST_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic scan;
        logic bump;
        logic inc;
        logic mul;
        logic add;
        logic div;
        logic write;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_record;
        logic is_bad;
        logic committed;
        logic scan_hit;
        logic scan_last;
        logic div_last;
    } t_dp_sts;

endpackage

/* src/etcas_ctrl.sv */
module etcas_ctrl import etcas_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_ctl
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_ctl.decode = 1'b1;
                if (i_sts.is_record) begin
                    n_state = i_sts.is_bad ? ST_FINISH : ST_INC;
                end else begin
                    n_state = i_sts.committed ? ST_BUMP : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_hit || i_sts.scan_last) begin
                    n_state = ST_BUMP;
                end
            end
            ST_BUMP: begin
                o_ctl.bump = 1'b1;
                n_state    = ST_FINISH;
            end
            ST_INC: begin
                o_ctl.inc = 1'b1;
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                o_ctl.add = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_ctl.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_ctl.write = 1'b1;
                n_state     = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The divider hands off to the mean write right after its last step
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_sts.div_last) |=> (r_state == ST_WRITE))
        else $error("divider did not hand off to mean write");

    // A bad record skips all state updates
    a_bad_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECODE && i_sts.is_record && i_sts.is_bad)
        |=> (r_state == ST_FINISH))
        else $error("bad record entered the update path");
`endif

endmodule

/* src/etcas_dp.sv */
module etcas_dp import etcas_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              i_cmd,
    input  logic [IDX_W-1:0]  i_arm_index,
    input  logic [DATA_W-1:0] i_reward,
    input  t_dp_cmd           i_ctl,
    output t_dp_sts           o_sts,
    output logic [IDX_W-1:0]  o_chosen_arm,
    output logic              o_committed,
    output logic              o_bad_arm
);

    // Configuration
    logic [DATA_W-1:0]  r_explore_limit;
    logic [NARMS_W-1:0] r_num_arms;

    // Per-arm state
    logic [DATA_W-1:0] r_mean       [NUM_ARMS];
    logic [DATA_W-1:0] r_choose_cnt [NUM_ARMS];
    logic [DATA_W-1:0] r_record_cnt [NUM_ARMS];
    logic              r_commit;
    logic [ARM_W-1:0]  r_commit_arm;

    // Working registers
    logic                r_cmd;
    logic [IDX_W-1:0]    r_idx;
    logic [DATA_W-1:0]   r_reward;
    logic [ARM_W-1:0]    r_ptr;
    logic [ARM_W-1:0]    r_best;
    logic [DATA_W-1:0]   r_best_mean;
    logic                r_bad;
    logic [DATA_W-1:0]   r_n;
    logic [2*DATA_W-1:0] r_acc;
    logic [DATA_W-1:0]   r_rem;
    logic [DATA_W-1:0]   r_quo;
    logic [DIVCNT_W-1:0] r_div_cnt;
    logic [IDX_W-1:0]    r_out_arm;
    logic                r_out_commit;
    logic                r_out_bad;

    logic [DATA_W-1:0]   mean_rd;
    logic [DATA_W-1:0]   choose_rd;
    logic [DATA_W-1:0]   record_rd;
    logic [ARMCNT_W-1:0] n_eff;
    logic                scan_hit;
    logic                scan_last;
    logic                is_bad;
    logic [ARM_W-1:0]    best_nx;
    logic [DATA_W-1:0]   best_mean_nx;
    logic [DATA_W-1:0]   choose_nx;
    logic [DATA_W-1:0]   record_nx;
    logic [2*DATA_W-1:0] sum;
    logic [DATA_W:0]     trial;
    logic [DATA_W:0]     diff;
    logic                ge;

    // Read the arm under the pointer
    assign mean_rd   = r_mean[r_ptr];
    assign choose_rd = r_choose_cnt[r_ptr];
    assign record_rd = r_record_cnt[r_ptr];

    // Clamp the arm count into 1..NUM_ARMS
    always_comb begin
        if (r_num_arms == '0) begin
            n_eff = ARMCNT_W'(1);
        end else if (32'(r_num_arms) > NUM_ARMS) begin
            n_eff = ARMCNT_W'(NUM_ARMS);
        end else begin
            n_eff = ARMCNT_W'(r_num_arms);
        end
    end

    // Scan step: exploration check and running best
    assign scan_hit     = choose_rd < r_explore_limit;
    assign scan_last    = (ARMCNT_W'(r_ptr) + ARMCNT_W'(1)) == n_eff;
    assign best_nx      = (mean_rd > r_best_mean) ? r_ptr : r_best;
    assign best_mean_nx = (mean_rd > r_best_mean) ? mean_rd : r_best_mean;
    assign is_bad       = 32'(r_idx) >= 32'(n_eff);

    // Saturating counters
    assign choose_nx = (choose_rd == CNT_MAX) ? choose_rd : choose_rd + DATA_W'(1);
    assign record_nx = (record_rd == CNT_MAX) ? record_rd : record_rd + DATA_W'(1);

    // Restoring divider step; quotient fits in DATA_W bits
    assign sum   = r_acc + (2*DATA_W)'(r_reward);
    assign trial = {r_rem, r_quo[DATA_W-1]};
    assign ge    = trial >= {1'b0, r_n};
    assign diff  = trial - {1'b0, r_n};

    assign o_sts.is_record = (r_cmd == CMD_RECORD);
    assign o_sts.is_bad    = is_bad;
    assign o_sts.committed = r_commit;
    assign o_sts.scan_hit  = scan_hit;
    assign o_sts.scan_last = scan_last;
    assign o_sts.div_last  = (r_div_cnt == DIVCNT_W'(DATA_W - 1));

    // Configuration, arm state and commitment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_explore_limit <= DATA_W'(1);
            r_num_arms      <= NARMS_W'(8);
            r_commit        <= 1'b0;
            r_commit_arm    <= '0;
            for (int i = 0; i < NUM_ARMS; i++) begin
                r_mean[i]       <= '0;
                r_choose_cnt[i] <= '0;
                r_record_cnt[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EXPLORE_LIMIT: r_explore_limit <= i_cfg_data;
                    CFG_NUM_ARMS:      r_num_arms      <= i_cfg_data[NARMS_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctl.scan && !scan_hit && scan_last) begin
                r_commit     <= 1'b1;
                r_commit_arm <= best_nx;
            end
            if (i_ctl.bump) begin
                r_choose_cnt[r_ptr] <= choose_nx;
            end
            if (i_ctl.inc) begin
                r_record_cnt[r_ptr] <= record_nx;
            end
            if (i_ctl.write) begin
                r_mean[r_ptr] <= r_quo;
            end
        end
    end

    // Request capture, scan, mean update and result
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_cmd;
            r_idx    <= i_arm_index;
            r_reward <= i_reward;
        end
        if (i_ctl.decode) begin
            if (r_cmd == CMD_CHOOSE) begin
                r_ptr       <= r_commit ? r_commit_arm : '0;
                r_best      <= '0;
                r_best_mean <= '0;
                r_bad       <= 1'b0;
            end else begin
                r_ptr <= ARM_W'(r_idx);
                r_bad <= is_bad;
            end
        end
        if (i_ctl.scan && !scan_hit) begin
            r_best      <= best_nx;
            r_best_mean <= best_mean_nx;
            r_ptr       <= scan_last ? best_nx : r_ptr + ARM_W'(1);
        end
        if (i_ctl.inc) begin
            r_n <= record_nx;
        end
        if (i_ctl.mul) begin
            r_acc <= (2*DATA_W)'(mean_rd) * (2*DATA_W)'(r_n - DATA_W'(1));
        end
        if (i_ctl.add) begin
            r_rem     <= sum[2*DATA_W-1:DATA_W];
            r_quo     <= sum[DATA_W-1:0];
            r_div_cnt <= '0;
        end
        if (i_ctl.div) begin
            r_rem     <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            r_quo     <= {r_quo[DATA_W-2:0], ge};
            r_div_cnt <= r_div_cnt + DIVCNT_W'(1);
        end
        if (i_ctl.out_load) begin
            r_out_arm    <= (r_cmd == CMD_RECORD) ? r_idx : IDX_W'(r_ptr);
            r_out_commit <= r_commit;
            r_out_bad    <= r_bad;
        end
    end

    assign o_chosen_arm = r_out_arm;
    assign o_committed  = r_out_commit;
    assign o_bad_arm    = r_out_bad;

`ifndef SYNTHESIS
    // Commitment is permanent
    a_commit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_commit |=> r_commit)
        else $error("commitment was dropped");

    // The committed arm never changes once chosen
    a_commit_arm_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_commit |=> $stable(r_commit_arm))
        else $error("committed arm changed");
`endif

endmodule

/* src/explore_then_commit_arm_selector.sv */
// Explore-then-commit bandit arm selector. A choose request returns the first arm (in index
// order) pulled fewer than explore_limit times; once every arm in use has reached the limit
// the block commits for good to the arm with the highest running mean (lowest index on
// ties). A record request folds an unsigned Q16.16 reward into one arm's running mean,
// truncating; a record for an arm at or above num_arms is flagged in bad_arm and changes
// nothing. One request is processed at a time. A choose steps through decode, bump and
// finish when already committed, and otherwise runs the one-arm-per-cycle scan between
// decode and bump. A record steps through decode, increment, multiply, add, the
// one-bit-per-cycle 64/32 divider, mean write and finish; a flagged record goes from
// decode straight to finish. The result sits in an output register, so the next request
// is taken while it waits. Write configuration only while the block is idle.
module explore_then_commit_arm_selector import etcas_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cmd,
    input  logic [IDX_W-1:0]  i_arm_index,
    input  logic [DATA_W-1:0] i_reward,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [IDX_W-1:0]  o_chosen_arm,
    output logic              o_committed,
    output logic              o_bad_arm
);

    t_dp_cmd ctl;
    t_dp_sts sts;

    // Sequencer
    etcas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // Arm state, scan and divider
    etcas_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_cmd),
        .i_arm_index  (i_arm_index),
        .i_reward     (i_reward),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .o_chosen_arm (o_chosen_arm),
        .o_committed  (o_committed),
        .o_bad_arm    (o_bad_arm)
    );

endmodule
